// ===== rtl/lpht_pkg.sv =====
// Package for the linear probing hash table: field widths, operation and
// result codes, and the command and status bundles between controller and datapath.
// No dependencies.
package lpht_pkg;

   localparam int KEY_W    = 31;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;
   localparam int OCC_W    = 5;

   // Bits of the stage counter of the home slot unit (three stages)
   localparam int HCNT_W   = 2;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_SEARCH = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 2'd0,
      ST_FOUND    = 2'd1,
      ST_MISSING  = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_wr;   // write an empty entry at the sweep index
      logic accept;     // latch the request beat
      logic hash_step;  // advance the home slot unit by one stage
      logic load_home;  // point the probe index at the home slot
      logic advance;    // move the probe index to the next slot
      logic finish;     // commit the decision and load the result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic hash_done;
      logic clear_last;
      logic probe_done;
      logic out_free;
   } stat_type;

endpackage

// ===== rtl/lpht_req_if.sv =====
// Request channel of the hash table: valid/ready handshake with op and key.
// Depends on lpht_pkg.
interface lpht_req_if;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [lpht_pkg::KEY_W-1:0] key;

   modport source (output valid, output op, output key, input ready);
   modport sink   (input valid, input op, input key, output ready);
endinterface

// ===== rtl/lpht_rsp_if.sv =====
// Result channel of the hash table: valid/ready handshake with status, slot
// and occupancy. Depends on lpht_pkg.
interface lpht_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lpht_pkg::STATUS_W-1:0] status;
   logic [lpht_pkg::SLOT_W-1:0]   slot;
   logic [lpht_pkg::OCC_W-1:0]    occupancy;

   modport source (output valid, output status, output slot, output occupancy,
                   input ready);
   modport sink   (input valid, input status, input slot, input occupancy,
                   output ready);
endinterface

// ===== rtl/lpht_ctrl.sv =====
// Controller of the hash table: clearing sweep, hashing and probe sequencing.
// Depends on lpht_pkg.
module lpht_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lpht_pkg::stat_type stat,
   output lpht_pkg::cmd_type  cmd
);
   import lpht_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_HASH  = 4'b0100,
      S_PROBE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cmd.advance  = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_HASH;
            end
         end
         S_HASH: begin
            if (stat.hash_done) begin
               cmd.load_home = 1'b1;
               state_in      = S_PROBE;
            end else begin
               cmd.hash_step = 1'b1;
            end
         end
         S_PROBE: begin
            if (stat.probe_done) begin
               // hold the decision until the result register is free
               if (stat.out_free) begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            end else begin
               cmd.advance = 1'b1;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

// ===== rtl/lpht_datapath.sv =====
// Datapath of the hash table: home slot unit, slot memory, probe index,
// decision logic, stored-key count and result register. Depends on lpht_pkg.
module lpht_datapath #(
   parameter int TABLE_SIZE = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lpht_pkg::cmd_type              cmd,
   output lpht_pkg::stat_type             stat,
   input  logic                           req_op,
   input  logic [lpht_pkg::KEY_W-1:0]     req_key,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lpht_pkg::STATUS_W-1:0]  rsp_status,
   output logic [lpht_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [lpht_pkg::OCC_W-1:0]     rsp_occupancy
);
   import lpht_pkg::*;

   localparam int  IDX_W = $clog2(TABLE_SIZE);
   localparam int  CNT_W = $clog2(TABLE_SIZE + 1);
   localparam int  SW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
   localparam int  CW    = (CNT_W > OCC_W) ? CNT_W : OCC_W;
   localparam bit  POW2  = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_SIZE);

   // Request registers
   logic             op_ff;
   logic [KEY_W-1:0] key_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_op;
         key_ff <= req_key;
      end
   end

   // Home slot: key modulo TABLE_SIZE
   logic [IDX_W-1:0] home_ff;

   if (POW2) begin : g_mask
      always_ff @(posedge clock) begin
         if (cmd.accept) begin
            home_ff <= req_key[IDX_W-1:0];
         end
      end
      assign stat.hash_done = 1'b1;
   end else begin : g_recip
      // Reciprocal multiplication: the quotient estimate falls short by at
      // most one, so a single compare and subtract finishes the remainder
      localparam logic [KEY_W-1:0] RECIP   = KEY_W'((64'd1 << KEY_W) / TABLE_SIZE);
      localparam logic [KEY_W-1:0] DIVISOR = KEY_W'(TABLE_SIZE);

      logic [HCNT_W-1:0]  hcnt_ff;
      logic [2*KEY_W-1:0] prod_ff;
      logic [KEY_W-1:0]   rem_ff;
      logic [KEY_W-1:0]   quot;

      assign quot = prod_ff[2*KEY_W-1:KEY_W];

      always_ff @(posedge clock) begin
         if (reset) begin
            hcnt_ff <= '0;
         end else if (cmd.accept) begin
            hcnt_ff <= HCNT_W'(3);
         end else if (cmd.hash_step) begin
            hcnt_ff <= hcnt_ff - HCNT_W'(1);
         end
      end

      // Stages: multiply, subtract the quotient times the size, correct
      always_ff @(posedge clock) begin
         if (cmd.hash_step) begin
            case (hcnt_ff)
               HCNT_W'(3): begin
                  prod_ff <= (2*KEY_W)'(key_ff) * (2*KEY_W)'(RECIP);
               end
               HCNT_W'(2): begin
                  rem_ff <= key_ff - quot * DIVISOR;
               end
               default: begin
                  if (rem_ff >= DIVISOR) begin
                     home_ff <= IDX_W'(rem_ff - DIVISOR);
                  end else begin
                     home_ff <= IDX_W'(rem_ff);
                  end
               end
            endcase
         end
      end
      assign stat.hash_done = (hcnt_ff == '0);
   end

   // Probe index and probe count
   logic [IDX_W-1:0] idx_ff, idx_in, idx_next;
   logic [CNT_W-1:0] n_ff, n_in;

   assign idx_next = (idx_ff == LAST_IDX) ? '0 : idx_ff + IDX_W'(1);

   always_comb begin
      idx_in = idx_ff;
      n_in   = n_ff;
      if (cmd.load_home) begin
         idx_in = home_ff;
         n_in   = '0;
      end else if (cmd.advance) begin
         idx_in = idx_next;
         n_in   = n_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         n_ff   <= '0;
      end else begin
         idx_ff <= idx_in;
         n_ff   <= n_in;
      end
   end

   assign stat.clear_last = (idx_ff == LAST_IDX);

   // Slot memory: {occupied, key}; read data follows idx_ff
   logic [KEY_W:0] mem [TABLE_SIZE];
   logic [KEY_W:0] rd_ff;
   logic           wr_en;
   logic [KEY_W:0] wr_data;
   logic           ins_ok;

   assign wr_en   = cmd.clear_wr | (cmd.finish & ins_ok);
   assign wr_data = cmd.clear_wr ? {1'b0, {KEY_W{1'b0}}} : {1'b1, key_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff] <= wr_data;
      end
      rd_ff <= mem[idx_in];
   end

   // Decision on the slot under the probe index
   logic       probe_all, occ, hit;
   status_type res_status;
   logic [IDX_W-1:0] res_idx;

   assign probe_all = (n_ff == FULL_CNT);
   assign occ       = rd_ff[KEY_W];
   assign hit       = occ & (rd_ff[KEY_W-1:0] == key_ff);

   always_comb begin
      ins_ok = 1'b0;
      if (probe_all) begin
         if (op_ff == OP_INSERT) begin
            res_status = ST_FULL;
            res_idx    = '0;
         end else begin
            res_status = ST_MISSING;
            res_idx    = home_ff;
         end
      end else if (!occ) begin
         res_idx = idx_ff;
         if (op_ff == OP_INSERT) begin
            res_status = ST_INSERTED;
            ins_ok     = 1'b1;
         end else begin
            res_status = ST_MISSING;
         end
      end else begin
         res_status = ST_FOUND;
         res_idx    = idx_ff;
      end
   end

   assign stat.probe_done = probe_all | !occ | ((op_ff == OP_SEARCH) & hit);

   // Stored-key count
   logic [CNT_W-1:0] count_ff, count_in;

   assign count_in = (cmd.finish & ins_ok) ? count_ff + CNT_W'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [OCC_W-1:0]    occ_ff;
   logic [SW-1:0]       slot_ext;
   logic [CW-1:0]       cnt_ext;

   assign slot_ext = SW'(res_idx);
   assign cnt_ext  = CW'(count_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         status_ff <= res_status;
         slot_ff   <= slot_ext[SLOT_W-1:0];
         occ_ff    <= cnt_ext[OCC_W-1:0];
      end
   end

   assign stat.out_free = !rsp_valid_ff | rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_slot      = slot_ff;
   assign rsp_occupancy = occ_ff;

endmodule

// ===== rtl/linear_probe_hash_table.sv =====
// Top level of the linear probing hash table: controller plus datapath.
// Depends on lpht_pkg, lpht_req_if, lpht_rsp_if, lpht_ctrl, lpht_datapath.
//
// Usage:
//   req_ch carries one operation per beat: op (insert or search) and a
//   31-bit key. rsp_ch returns exactly one beat per request: status
//   (inserted, found, not found, table full), slot index and the number
//   of stored keys after the operation.
//   One request is in work at a time. From the request beat, the probe
//   starts at the home slot and steps over 0 to TABLE_SIZE slots before
//   the result beat is valid. The probe loop reads one slot of the slot
//   memory per cycle. When TABLE_SIZE is not a power of two the home slot
//   comes from a reciprocal-multiply remainder unit that multiplies,
//   subtracts and corrects in turn.
//   The next request is taken the cycle after the result is loaded.
//   Reset starts a clearing pass that marks every slot empty; req_ch.ready
//   stays low until it ends.
//   A stalled result is held in the output register; a finished probe
//   waits for that register to drain before it commits.
module linear_probe_hash_table #(
   parameter int TABLE_SIZE = 16
) (
   input  logic       clock,
   input  logic       reset,
   lpht_req_if.sink   req_ch,
   lpht_rsp_if.source rsp_ch
);
   import lpht_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   lpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lpht_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_op        (req_ch.op),
      .req_key       (req_ch.key),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_status    (rsp_ch.status),
      .rsp_slot      (rsp_ch.slot),
      .rsp_occupancy (rsp_ch.occupancy)
   );

endmodule

// ===== rtl/lpht_checker.sv =====
// Port-level assertions for the hash table and the bind that attaches them.
// Depends on lpht_pkg and linear_probe_hash_table.
module lpht_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [lpht_pkg::STATUS_W-1:0] rsp_status,
   input logic [lpht_pkg::SLOT_W-1:0]   rsp_slot,
   input logic [lpht_pkg::OCC_W-1:0]    rsp_occupancy
);
   import lpht_pkg::*;

   // The clearing pass keeps requests out right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

   // One request in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while one is in work");

   // A full-table result reports slot zero
   a_full_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_slot == '0))
      else $error("full-table result with nonzero slot");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         ($stable(rsp_status) && $stable(rsp_slot) && $stable(rsp_occupancy)))
      else $error("result payload changed while stalled");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_status    (rsp_ch.status),
   .rsp_slot      (rsp_ch.slot),
   .rsp_occupancy (rsp_ch.occupancy)
);

// ===== tb/tb_linear_probe_hash_table.sv =====
// Self-checking bench for linear_probe_hash_table: drives insert and search
// beats, predicts each status, slot and count, and checks every result beat.
// Depends on lpht_pkg, lpht_req_if, lpht_rsp_if and the top level of the block.
module tb_linear_probe_hash_table;
   import lpht_pkg::*;

   localparam int TABLE_SIZE  = 16;
   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 300;
   localparam int SPARSE_OPS  = 700;
   localparam int FULL_OPS    = 700;
   localparam int PRESSURE_OPS = 24;
   // All ones is the empty marker of the original table; here it is a plain key
   localparam logic [KEY_W-1:0] KEY_TOP = '1;

   typedef struct packed {
      status_type              status;
      logic [SLOT_W-1:0]       slot;
      logic [OCC_W-1:0]        occupancy;
   } probe_outcome_type;

   logic clock = 1'b0;
   logic reset;

   lpht_req_if req_ch ();
   lpht_rsp_if rsp_ch ();

   linear_probe_hash_table #(
      .TABLE_SIZE (TABLE_SIZE)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow of the table contents, updated when a request beat is accepted
   logic [KEY_W-1:0] shadow_keys [TABLE_SIZE];
   bit               shadow_used [TABLE_SIZE];
   int               stored_count = 0;

   probe_outcome_type expected_outcomes [$];

   // Pacing controls shared by the test tasks and the result-side process
   bit tx_idle_en  = 1'b0;
   bit rx_idle_en  = 1'b0;
   bit rx_hold_req = 1'b0;

   int error_count     = 0;
   int results_checked = 0;
   int inserts_sent    = 0;
   int searches_sent   = 0;
   int full_rejects    = 0;
   int cycle_count     = 0;

   // Clock: 4 units high, 4 units low
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Abort the run if it hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending",
                  cycle_count, expected_outcomes.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // Gap length: mostly short, now and then long
   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 75) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Random 31-bit key moved onto the given home slot
   function automatic logic [KEY_W-1:0] key_with_home(int unsigned home);
      logic [KEY_W-1:0] k;
      k = KEY_W'($urandom);
      return KEY_W'(k - (k % TABLE_SIZE) + home);
   endfunction

   // Key mix that reaches deep into probe chains: stored keys, keys that
   // collide with stored ones, range extremes and fully random keys
   function automatic logic [KEY_W-1:0] pick_key();
      int unsigned sel;
      int unsigned idx;
      sel = $urandom_range(0, 7);
      idx = $urandom_range(0, TABLE_SIZE - 1);
      if (sel < 3 && shadow_used[idx]) return shadow_keys[idx];
      if (sel < 5) return key_with_home(idx);
      if (sel == 5) begin
         case ($urandom_range(0, 2))
            0:       return '0;
            1:       return KEY_TOP;
            default: return KEY_TOP - 1'b1;
         endcase
      end
      return KEY_W'($urandom);
   endfunction

   // Walk the shadow table for one operation and return what the block owes
   function automatic probe_outcome_type predict_probe(op_type op, logic [KEY_W-1:0] key);
      probe_outcome_type r;
      int unsigned    home;
      int unsigned    idx;
      int             n;
      bit             done;
      home = key % TABLE_SIZE;
      idx  = home;
      done = 1'b0;
      // Defaults cover the table-full insert and the search that wraps home
      if (op == OP_INSERT) begin
         r.status = ST_FULL;
         r.slot   = '0;
      end else begin
         r.status = ST_MISSING;
         r.slot   = SLOT_W'(home);
      end
      for (n = 0; n < TABLE_SIZE && !done; n++) begin
         if (!shadow_used[idx]) begin
            if (op == OP_INSERT) begin
               shadow_keys[idx] = key;
               shadow_used[idx] = 1'b1;
               stored_count++;
               r.status = ST_INSERTED;
            end else begin
               r.status = ST_MISSING;
            end
            r.slot = SLOT_W'(idx);
            done   = 1'b1;
         end else if (op == OP_SEARCH && shadow_keys[idx] == key) begin
            r.status = ST_FOUND;
            r.slot   = SLOT_W'(idx);
            done     = 1'b1;
         end
         idx = (idx + 1 >= TABLE_SIZE) ? 0 : idx + 1;
      end
      r.occupancy = OCC_W'(stored_count);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      if (error_count <= 50)
         $display("[%0t] mismatch in %s: got 0x%0h, want 0x%0h (result %0d)",
                  $time, what, got, want, results_checked);
   endtask

   // Offer one request beat and hold it until accepted; record its outcome.
   // Keep valid high when no gap follows so back-to-back beats stay clean.
   task automatic send_beat(op_type op, logic [KEY_W-1:0] key);
      probe_outcome_type outcome;
      int             gap;
      req_ch.valid <= 1'b1;
      req_ch.op    <= op;
      req_ch.key   <= key;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      outcome = predict_probe(op, key);
      expected_outcomes.push_back(outcome);
      if (op == OP_INSERT) inserts_sent++;
      else searches_sent++;
      if (outcome.status == ST_FULL) full_rejects++;
      if (tx_idle_en && $urandom_range(0, 2) == 0) begin
         gap = idle_len();
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid, then wait for every outstanding result beat
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_outcomes.size() != 0) @(posedge clock);
   endtask

   // Result side: hold ready low on request for a long count, else idle at random
   initial begin : rsp_pacer
      int hold_count;
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
               @(posedge clock);
         end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = idle_len();
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Compare every accepted result beat against the oldest expectation
   always @(posedge clock) begin : result_check
      probe_outcome_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_outcomes.size() == 0) begin
            report_mismatch("unexpected result beat, status", 32'(rsp_ch.status), '0);
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
            if (rsp_ch.slot !== want.slot)
               report_mismatch("slot", 32'(rsp_ch.slot), 32'(want.slot));
            if (rsp_ch.occupancy !== want.occupancy)
               report_mismatch("occupancy", 32'(rsp_ch.occupancy), 32'(want.occupancy));
         end
         results_checked++;
      end
   end

   // Directed: empty-table search, extreme keys, duplicates, wrapping
   // probe chains and a search that stops on an empty slot. Run without gaps.
   task automatic test_empty_and_collisions();
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      send_beat(OP_SEARCH, '0);            // nothing stored yet
      send_beat(OP_SEARCH, KEY_TOP - 1'b1);
      send_beat(OP_INSERT, '0);
      send_beat(OP_INSERT, KEY_TOP);       // empty marker value, home 15
      send_beat(OP_INSERT, KEY_TOP - 1'b1);
      send_beat(OP_INSERT, KEY_W'(5));
      send_beat(OP_INSERT, KEY_W'(5));     // duplicate lands in the next slot
      send_beat(OP_INSERT, KEY_W'(31));    // home 15, wraps past 0 to 1
      send_beat(OP_SEARCH, KEY_W'(31));    // found after a wrap
      send_beat(OP_SEARCH, KEY_TOP);
      send_beat(OP_SEARCH, KEY_W'(5));
      send_beat(OP_SEARCH, KEY_W'(21));    // chain 5, 6 then empty slot 7
      drain_results();
   endtask

   // Random: mostly searches on a partly filled table, inserts trickle in
   task automatic test_sparse_random();
      int i;
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      for (i = 0; i < SPARSE_OPS; i++) begin
         if ($urandom_range(0, 69) == 0) send_beat(OP_INSERT, pick_key());
         else send_beat(OP_SEARCH, pick_key());
      end
      drain_results();
   endtask

   // Back-pressure: stall the result side for a long count while requests
   // keep coming, so the block fills and holds its request ready low
   task automatic test_backpressure();
      int i;
      tx_idle_en  = 1'b0;
      rx_idle_en  = 1'b0;
      rx_hold_req = 1'b1;
      for (i = 0; i < PRESSURE_OPS; i++) send_beat(OP_SEARCH, pick_key());
      drain_results();
   endtask

   // Directed: fill every slot, then insert into a full table and search
   // for an absent key so the probe wraps back to its home slot
   task automatic test_fill_to_full();
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b1;
      while (stored_count < TABLE_SIZE) send_beat(OP_INSERT, key_with_home(2));
      send_beat(OP_INSERT, KEY_W'($urandom));
      send_beat(OP_SEARCH, key_with_home(3));
      drain_results();
   endtask

   // Random on the full table: long probe chains, wraps and rejected inserts;
   // reshuffle the idle pattern now and then to get stretches without gaps
   task automatic test_full_random();
      int i;
      for (i = 0; i < FULL_OPS; i++) begin
         if (i % 100 == 0) begin
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 99) < 35) send_beat(OP_INSERT, pick_key());
         else send_beat(OP_SEARCH, pick_key());
      end
      drain_results();
   endtask

   initial begin : run_tests
      int n;
      for (n = 0; n < TABLE_SIZE; n++) begin
         shadow_keys[n] = '0;
         shadow_used[n] = 1'b0;
      end
      req_ch.valid <= 1'b0;
      req_ch.op    <= OP_INSERT;
      req_ch.key   <= '0;
      reset        <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Request ready stays low through the clearing pass; send_beat waits on it
      test_empty_and_collisions();
      test_sparse_random();
      test_backpressure();
      test_fill_to_full();
      test_full_random();

      // Let any stray beat show up before closing
      repeat (TABLE_SIZE + 4) @(posedge clock);

      $display("ran %0d inserts (%0d hit a full table) and %0d searches",
               inserts_sent, full_rejects, searches_sent);
      $display("checked %0d result beats, %0d mismatches, final count %0d",
               results_checked, error_count, stored_count);
      if (error_count == 0 && expected_outcomes.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/lpht_pkg.sv
rtl/lpht_req_if.sv
rtl/lpht_rsp_if.sv
rtl/lpht_ctrl.sv
rtl/lpht_datapath.sv
rtl/linear_probe_hash_table.sv
rtl/lpht_checker.sv
tb/tb_linear_probe_hash_table.sv
